>>> rtl/core/sha1_pkg.sv
`default_nettype none

package sha1_pkg;

  localparam int unsigned ChainWords = 5;
  localparam int unsigned BlockWords = 16;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [2:0] LastWordIdx = 3'd4;

  localparam logic [31:0] Iv [ChainWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic       put;        // shift one byte into the block
    byte_sel_e  sel;
    logic       count;      // message byte: add 8 to the bit count
    logic [2:0] len_idx;    // length byte, 7 is the most significant
    logic       load_work;  // a..e <= chaining words
    logic       do_round;
    logic [6:0] round;
    logic       chain_add;
    logic       init;       // back to the initial state for a new message
    logic [2:0] out_idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pos_last;  // block byte position is 63
    logic pos_56;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/sha1_in_if.sv
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sha1_out_if.sv
`default_nettype none

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sha1_dp.sv
`default_nettype none

module sha1_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sha1_pkg::cmd_t cmd_i,
  input  wire logic [7:0]     data_byte_i,
  output sha1_pkg::sts_t      sts_o,
  output logic [31:0]         digest_word_o
);
  import sha1_pkg::*;

  logic [31:0] blk_q [BlockWords];
  logic [31:0] blk_d [BlockWords];
  logic [31:0] work_q [ChainWords];
  logic [31:0] work_d [ChainWords];
  logic [31:0] chain_q [ChainWords];
  logic [31:0] chain_d [ChainWords];
  logic [63:0] bit_cnt_q, bit_cnt_d;
  logic [5:0]  pos_q, pos_d;

  logic [7:0]  byte_val;
  logic [31:0] w_mix, w_t, f_val, k_val, tmp;

  always_comb begin
    unique case (cmd_i.sel)
      BSEL_IN:   byte_val = data_byte_i;
      BSEL_PAD:  byte_val = PadByte;
      BSEL_ZERO: byte_val = 8'h00;
      BSEL_LEN:  byte_val = bit_cnt_q[{cmd_i.len_idx, 3'b000} +: 8];
      default:   byte_val = 8'h00;
    endcase
  end

  // schedule window holds W[t-16..t-1] at slots 0..15
  assign w_mix = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
  assign w_t   = (cmd_i.round < 7'd16) ? blk_q[0] : {w_mix[30:0], w_mix[31]};

  always_comb begin
    priority if (cmd_i.round < 7'd20) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = K0;
    end else if (cmd_i.round < 7'd40) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K1;
    end else if (cmd_i.round < 7'd60) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) | (work_q[2] & work_q[3]);
      k_val = K2;
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K3;
    end
  end

  assign tmp = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + k_val + w_t;

  always_comb begin
    blk_d     = blk_q;
    work_d    = work_q;
    chain_d   = chain_q;
    bit_cnt_d = bit_cnt_q;
    pos_d     = pos_q;

    if (cmd_i.put) begin
      // whole block moves up one byte; first byte ends in the top of word 0
      for (int i = 0; i < BlockWords - 1; i++) begin
        blk_d[i] = {blk_q[i][23:0], blk_q[i+1][31:24]};
      end
      blk_d[BlockWords-1] = {blk_q[BlockWords-1][23:0], byte_val};
      pos_d = pos_q + 6'd1;
      if (cmd_i.count) begin
        bit_cnt_d = bit_cnt_q + 64'd8;
      end
    end

    if (cmd_i.do_round) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        blk_d[i] = blk_q[i+1];
      end
      blk_d[BlockWords-1] = w_t;
      work_d[0] = tmp;
      work_d[1] = work_q[0];
      work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
      work_d[3] = work_q[2];
      work_d[4] = work_q[3];
    end

    if (cmd_i.load_work) begin
      work_d = chain_q;
    end

    if (cmd_i.chain_add) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end

    if (cmd_i.init) begin
      chain_d   = Iv;
      bit_cnt_d = '0;
      pos_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q   <= Iv;
      bit_cnt_q <= '0;
      pos_q     <= '0;
    end else begin
      chain_q   <= chain_d;
      bit_cnt_q <= bit_cnt_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    work_q <= work_d;
  end

  assign sts_o.pos_last = (pos_q == 6'd63);
  assign sts_o.pos_56   = (pos_q == 6'd56);
  assign digest_word_o  = chain_q[cmd_i.out_idx];

endmodule

`default_nettype wire

>>> rtl/core/sha1_ctrl.sv
`default_nettype none

module sha1_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           has_byte_i,
  input  wire logic           end_of_message_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [2:0]          word_index_o,
  output logic                last_word_o,
  input  wire sha1_pkg::sts_t sts_i,
  output sha1_pkg::cmd_t      cmd_o
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUT   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // where the message stands in padding
  localparam logic [2:0] PH_DATA = 3'd0;
  localparam logic [2:0] PH_P80  = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] ph_q, ph_d;
  logic [2:0] len_q, len_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] widx_q, widx_d;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    len_d   = len_q;
    rnd_d   = rnd_q;
    widx_d  = widx_q;

    cmd_o           = '0;
    cmd_o.sel       = BSEL_IN;
    cmd_o.len_idx   = len_q;
    cmd_o.round     = rnd_q;
    cmd_o.out_idx   = widx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (has_byte_i) begin
            cmd_o.put   = 1'b1;
            cmd_o.count = 1'b1;
          end
          if (end_of_message_i) begin
            ph_d    = PH_P80;
            state_d = S_PUT;
          end
        end
      end
      S_PUT: begin
        unique case (ph_q)
          PH_P80: begin
            cmd_o.put = 1'b1;
            cmd_o.sel = BSEL_PAD;
            ph_d      = PH_ZERO;
          end
          PH_ZERO: begin
            if (sts_i.pos_56) begin
              ph_d  = PH_LEN;
              len_d = 3'd7;
            end else begin
              cmd_o.put = 1'b1;
              cmd_o.sel = BSEL_ZERO;
            end
          end
          PH_LEN: begin
            cmd_o.put = 1'b1;
            cmd_o.sel = BSEL_LEN;
            len_d     = len_q - 3'd1;
            if (len_q == 3'd0) begin
              ph_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      S_ROUND: begin
        cmd_o.do_round = 1'b1;
        if (rnd_q == LastRound) begin
          state_d = S_FINAL;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      S_FINAL: begin
        cmd_o.chain_add = 1'b1;
        priority if (ph_q == PH_DATA) begin
          state_d = S_IDLE;
        end else if (ph_q == PH_DONE) begin
          state_d = S_OUT;
          widx_d  = '0;
        end else begin
          state_d = S_PUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (widx_q == LastWordIdx) begin
            cmd_o.init = 1'b1;
            ph_d       = PH_DATA;
            state_d    = S_IDLE;
          end else begin
            widx_d = widx_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a byte landing in position 63 completes the block
    if (cmd_o.put && sts_i.pos_last) begin
      cmd_o.load_work = 1'b1;
      state_d         = S_ROUND;
      rnd_d           = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_DATA;
      len_q   <= '0;
      rnd_q   <= '0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      len_q   <= len_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign word_index_o = widx_q;
  assign last_word_o  = (widx_q == LastWordIdx);

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> rnd_q <= LastRound)
    else $error("round counter past last round");

  a_len_fills_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && ph_q == PH_LEN && len_q == 3'd0) |-> sts_i.pos_last)
    else $error("last length byte not at end of block");

  a_out_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_ready_i && widx_q == LastWordIdx) |=>
      (state_q == S_IDLE && ph_q == PH_DATA))
    else $error("no return to idle after digest");

  a_final_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINAL |-> $past(state_q) == S_ROUND && $past(rnd_q) == LastRound)
    else $error("chain update without full compression");

endmodule

`default_nettype wire

>>> rtl/core/sha1_hash_engine.sv
`default_nettype none

// SHA-1 engine. Takes a message one byte per item (has_byte marks a real byte,
// end_of_message closes the message; an end item without a byte is allowed) and
// returns the 160-bit digest as five items, h0 first, last_word set on h4.
// Bytes are taken one per cycle while a block fills; each completed 64-byte
// block then holds the input through 80 rounds of one shared round unit and
// the chaining add. At the end of a message the padding bytes (up to 72) go
// in one per cycle, but for a pause before the length bytes and one or two
// further compressions, after which the five digest items are offered one per
// cycle while the sink takes them.
// No input is taken from the end item until the last digest word has gone.
module sha1_hash_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha1_in_if.sink   in_i,
  sha1_out_if.source out_o
);
  import sha1_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sha1_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .has_byte_i       (in_i.has_byte),
    .end_of_message_i (in_i.end_of_message),
    .in_ready_o       (in_i.ready),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .word_index_o     (out_o.word_index),
    .last_word_o      (out_o.last_word),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  sha1_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_i.data_byte),
    .sts_o         (sts),
    .digest_word_o (out_o.digest_word)
  );

endmodule

`default_nettype wire

>>> verif/sha1_hash_engine_tb.sv
`timescale 1ns / 100ps

module sha1_hash_engine_tb;
  import sha1_pkg::*;

  localparam int unsigned SinkHoldCycles = 300;
  localparam int unsigned StallLimit     = 3000;
  localparam int unsigned DrainCycles    = 300;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  logic clk_i;
  logic rst_ni;

  sha1_in_if  in_if ();
  sha1_out_if out_if ();

  sha1_hash_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // golden SHA-1 state
  logic [31:0] hash_h [ChainWords];
  logic [31:0] msg_w [BlockWords];
  logic [63:0] msg_bits;
  logic [5:0]  blk_pos;

  digest_item_t digest_q[$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned ignored_sent;
  int unsigned messages_sent;
  int unsigned words_checked;
  int unsigned quiet_cycles;
  bit          calm;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void restart_message();
    hash_h   = Iv;
    msg_bits = '0;
    blk_pos  = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] a, b, c, d, e, f, k, t, w;
    logic [31:0] sched [BlockWords];
    sched = msg_w;
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w = sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^ sched[(r - 14) & 15] ^ sched[r & 15];
        sched[r & 15] = {w[30:0], w[31]};
      end
      w = sched[r & 15];
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    msg_w = sched;
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] value);
    logic [3:0] idx;
    idx = blk_pos[5:2];
    msg_w[idx] = {msg_w[idx][23:0], value};
    blk_pos++;
    if (blk_pos == '0) compress_block();
  endfunction

  // works out the digest words that one item will release
  function automatic void hash_item(input logic [7:0] data, input logic has,
                                    input logic last);
    logic [63:0]  len;
    digest_item_t dw;
    if (has) begin
      absorb_byte(data);
      msg_bits += 64'd8;
    end
    if (last) begin
      len = msg_bits;
      absorb_byte(PadByte);
      while (blk_pos != 6'd56) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(len[8 * i +: 8]);
      for (int i = 0; i < ChainWords; i++) begin
        dw.word = hash_h[i];
        dw.idx  = 3'(i);
        dw.last = (3'(i) == LastWordIdx);
        digest_q.insert(digest_q.size(), dw);
      end
      restart_message();
    end
  endfunction

  // valid stays up until the item is taken, so the item can be hashed as soon
  // as it is offered
  task automatic send_item(input logic [7:0] data, input logic has, input logic last);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= data;
    in_if.has_byte       <= has;
    in_if.end_of_message <= last;
    hash_item(data, has, last);
    if (has || last) items_sent++;
    else ignored_sent++;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_message(input int unsigned len);
    int unsigned n_body;
    logic        carry;
    carry  = (len != 0) && ($urandom_range(0, 1) == 1);
    n_body = carry ? len - 1 : len;
    for (int unsigned i = 0; i < n_body; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), carry, 1'b1);
    messages_sent++;
  endtask

  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return $urandom_range(0, 8);
    if (sel <= 7) return $urandom_range(9, 40);
    if (sel == 8) return $urandom_range(54, 66);
    return 0;
  endfunction

  task automatic test_directed();
    // empty message
    send_item(8'h00, 1'b0, 1'b1);
    // "abc", last byte on the end item
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // bytes 00 FF between items with neither byte nor end, then a stray byte on an end item without has_byte
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // one-byte messages at both extremes, then empty again straight after
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    messages_sent += 6;
  endtask

  // 55: padding fits; 56: length spills into a second block; 64: full block first
  task automatic test_block_boundaries();
    send_message(55);
    send_message(56);
    send_message(64);
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    send_message(12);
    send_message(6);
    send_message(0);
  endtask

  task automatic test_random_messages();
    while (items_sent < 220) send_message(pick_length());
  endtask

  task automatic test_steady_tail();
    calm = 1'b1;
    while (items_sent < 255) send_message($urandom_range(0, 12));
  endtask

  // sink side: short random stalls, or one long hold-off on request
  initial begin : sink_side
    int unsigned span;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (SinkHoldCycles) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        span = $urandom_range(1, 9);
        repeat (span) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_digest
    digest_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest item: expected none, got word %h idx %0d last %b",
                 $time, out_if.digest_word, out_if.word_index, out_if.last_word);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        words_checked++;
        if (out_if.digest_word !== want.word) begin
          $display("%0t: digest_word mismatch: expected %h, got %h",
                   $time, want.word, out_if.digest_word);
          fail_count++;
        end
        if (out_if.word_index !== want.idx) begin
          $display("%0t: word_index mismatch: expected %0d, got %0d",
                   $time, want.idx, out_if.word_index);
          fail_count++;
        end
        if (out_if.last_word !== want.last) begin
          $display("%0t: last_word mismatch: expected %b, got %b",
                   $time, want.last, out_if.last_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles, %0d digest words outstanding",
               $time, quiet_cycles, digest_q.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.has_byte       = 1'b0;
    in_if.end_of_message = 1'b0;
    rst_ni        = 1'b0;
    fail_count    = 0;
    items_sent    = 0;
    ignored_sent  = 0;
    messages_sent = 0;
    words_checked = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    msg_w         = '{default: '0};
    restart_message();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_block_boundaries();
    test_output_backpressure();
    test_random_messages();
    test_steady_tail();

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (digest_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Hashed %0d messages from %0d items (plus %0d idle items), incl. empty,",
             messages_sent, items_sent, ignored_sent);
    $display("55/56/64-byte boundaries and a long sink hold-off; %0d digest words checked.",
             words_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
